FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the ray/sphere intersection RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define RSI_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define RSI_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: design/rsi_pkg.sv
// ----------------------------------------------------------------------------
// rsi_pkg
// Shared constants and types of the ray/sphere intersection block.
// ----------------------------------------------------------------------------
`default_nettype none

package rsi_pkg;

    // Default coordinate format.
    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;

    // Depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] REG_CENTER_X  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CENTER_Y  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CENTER_Z  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_RADIUS    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_DISC_EPS  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_DIST_EPS  = 3'd5;

    // Reset values of the thresholds.
    localparam int DISC_EPS_RESET = 1;
    localparam int DIST_EPS_RESET = 66;

    // Classification of one item, passed from the front to the back.
    typedef struct packed {
        logic miss;
        logic tangent;
        logic c_neg;
    } t_flags;

endpackage

`default_nettype wire

FILE: design/rsi_mul.sv
// ----------------------------------------------------------------------------
// rsi_mul
// Pipelined signed multiplier built from four half-width partial products.
// ----------------------------------------------------------------------------
`default_nettype none

module rsi_mul #(
    parameter int AW = 32,
    parameter int BW = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_en,
    input  wire logic signed [AW-1:0]  i_a,
    input  wire logic signed [BW-1:0]  i_b,
    output logic signed [AW+BW-1:0]    o_p
);

    localparam int AL = AW / 2;
    localparam int AH = AW - AL;
    localparam int BL = BW / 2;
    localparam int BH = BW - BL;
    localparam int PW = AW + BW;

    logic          r_neg;
    logic [AW-1:0] r_ua;
    logic [BW-1:0] r_ub;
    logic          r_neg2;
    logic [AL+BL-1:0] r_p0;
    logic [AL+BH-1:0] r_p1;
    logic [AH+BL-1:0] r_p2;
    logic [AH+BH-1:0] r_p3;
    logic [PW-1:0] r_p;

    logic [AW-1:0] n_ua;
    logic [BW-1:0] n_ub;
    logic [PW-1:0] n_sum;

    // Magnitudes of the operands.
    assign n_ua = i_a[AW-1] ? (~i_a + 1'b1) : i_a;
    assign n_ub = i_b[BW-1] ? (~i_b + 1'b1) : i_b;

    // Sum of the partial products, each at the weight of its operand halves.
    assign n_sum = PW'(r_p0) + (PW'(r_p1) << BL) + (PW'(r_p2) << AL)
                 + (PW'(r_p3) << (AL + BL));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg  <= i_a[AW-1] ^ i_b[BW-1];
            r_ua   <= n_ua;
            r_ub   <= n_ub;
            r_neg2 <= r_neg;
            r_p0   <= r_ua[AL-1:0] * r_ub[BL-1:0];
            r_p1   <= r_ua[AL-1:0] * r_ub[BW-1:BL];
            r_p2   <= r_ua[AW-1:AL] * r_ub[BL-1:0];
            r_p3   <= r_ua[AW-1:AL] * r_ub[BW-1:BL];
            r_p    <= r_neg2 ? (~n_sum + 1'b1) : n_sum;
        end
    end

    assign o_p = $signed(r_p);

endmodule

`default_nettype wire

FILE: design/rsi_front.sv
// ----------------------------------------------------------------------------
// rsi_front
// Accepts rays, forms the quadratic coefficients and the discriminant, and
// classifies each item before it enters the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module rsi_front #(
    parameter int COORD_WIDTH = rsi_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = rsi_pkg::FRAC_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic signed [COORD_WIDTH-1:0] i_origin_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_origin_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_origin_z,
    input  wire logic signed [COORD_WIDTH-1:0] i_dir_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_dir_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_dir_z,
    input  wire logic signed [COORD_WIDTH-1:0] i_center_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_center_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_center_z,
    input  wire logic [COORD_WIDTH-2:0]        i_radius,
    input  wire logic [2*FRAC_BITS-1:0]        i_disc_eps,
    input  wire logic                          i_full,
    output logic                               o_push,
    output logic [2*COORD_WIDTH-1:0]           o_a,
    output logic signed [2*COORD_WIDTH+3:0]    o_b,
    output logic signed [4*COORD_WIDTH+7:0]    o_disc,
    output rsi_pkg::t_flags                    o_flags
);

    localparam int W   = COORD_WIDTH;
    localparam int MW  = W + 1;
    localparam int AW  = 2 * W;
    localparam int BW  = 2 * W + 4;
    localparam int CW  = 2 * W + 3;
    localparam int DW  = 4 * W + 8;
    localparam int ACW = AW + 1 + CW;

    logic en;
    logic [10:1] r_v;

    logic signed [MW-1:0] r_m_x, r_m_y, r_m_z;
    logic signed [W-1:0]  r_d_x, r_d_y, r_d_z;

    logic signed [2*W-1:0]   p_dd_x, p_dd_y, p_dd_z, p_rr;
    logic signed [2*W:0]     p_dm_x, p_dm_y, p_dm_z;
    logic signed [2*W+1:0]   p_mm_x, p_mm_y, p_mm_z;
    logic signed [DW-1:0]    p_bb;
    logic signed [ACW-1:0]   p_ac;

    logic [AW-1:0]        r_a5;
    logic signed [BW-1:0] r_b5;
    logic signed [CW-1:0] r_c5;
    logic [AW-1:0]        r_a_dl [0:2];
    logic signed [BW-1:0] r_b_dl [0:2];
    logic                 r_cn_dl [0:2];

    logic [AW-1:0]        r_a9;
    logic signed [BW-1:0] r_b9;
    logic                 r_cn9;
    logic signed [DW-1:0] r_disc9;

    logic [AW-1:0]        r_a10;
    logic signed [BW-1:0] r_b10;
    logic signed [DW-1:0] r_disc10;
    rsi_pkg::t_flags      r_flags10;
    rsi_pkg::t_flags      n_flags;

    // The pipeline moves unless the last item is waiting on a full queue.
    assign en      = !r_v[10] || !i_full;
    assign o_ready = en;
    assign o_push  = r_v[10] && !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[9:1], i_valid};
        end
    end

    // Ray origin relative to the sphere center.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m_x <= $signed({i_origin_x[W-1], i_origin_x}) - $signed({i_center_x[W-1], i_center_x});
            r_m_y <= $signed({i_origin_y[W-1], i_origin_y}) - $signed({i_center_y[W-1], i_center_y});
            r_m_z <= $signed({i_origin_z[W-1], i_origin_z}) - $signed({i_center_z[W-1], i_center_z});
            r_d_x <= i_dir_x;
            r_d_y <= i_dir_y;
            r_d_z <= i_dir_z;
        end
    end

    // Products for the dot products and the squared radius.
    rsi_mul #(.AW(W), .BW(W)) u_dd_x (.i_clk, .i_en(en), .i_a(r_d_x), .i_b(r_d_x), .o_p(p_dd_x));
    rsi_mul #(.AW(W), .BW(W)) u_dd_y (.i_clk, .i_en(en), .i_a(r_d_y), .i_b(r_d_y), .o_p(p_dd_y));
    rsi_mul #(.AW(W), .BW(W)) u_dd_z (.i_clk, .i_en(en), .i_a(r_d_z), .i_b(r_d_z), .o_p(p_dd_z));
    rsi_mul #(.AW(W), .BW(MW)) u_dm_x (.i_clk, .i_en(en), .i_a(r_d_x), .i_b(r_m_x), .o_p(p_dm_x));
    rsi_mul #(.AW(W), .BW(MW)) u_dm_y (.i_clk, .i_en(en), .i_a(r_d_y), .i_b(r_m_y), .o_p(p_dm_y));
    rsi_mul #(.AW(W), .BW(MW)) u_dm_z (.i_clk, .i_en(en), .i_a(r_d_z), .i_b(r_m_z), .o_p(p_dm_z));
    rsi_mul #(.AW(MW), .BW(MW)) u_mm_x (.i_clk, .i_en(en), .i_a(r_m_x), .i_b(r_m_x), .o_p(p_mm_x));
    rsi_mul #(.AW(MW), .BW(MW)) u_mm_y (.i_clk, .i_en(en), .i_a(r_m_y), .i_b(r_m_y), .o_p(p_mm_y));
    rsi_mul #(.AW(MW), .BW(MW)) u_mm_z (.i_clk, .i_en(en), .i_a(r_m_z), .i_b(r_m_z), .o_p(p_mm_z));
    rsi_mul #(.AW(W), .BW(W)) u_rr (
        .i_clk, .i_en(en),
        .i_a($signed({1'b0, i_radius})), .i_b($signed({1'b0, i_radius})), .o_p(p_rr)
    );

    // Coefficients a, b and c.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a5 <= AW'(p_dd_x) + AW'(p_dd_y) + AW'(p_dd_z);
            r_b5 <= (BW'(p_dm_x) + BW'(p_dm_y) + BW'(p_dm_z)) <<< 1;
            r_c5 <= CW'(p_mm_x) + CW'(p_mm_y) + CW'(p_mm_z) - CW'(p_rr);
        end
    end

    // Products for the discriminant.
    rsi_mul #(.AW(BW), .BW(BW)) u_bb (.i_clk, .i_en(en), .i_a(r_b5), .i_b(r_b5), .o_p(p_bb));
    rsi_mul #(.AW(AW + 1), .BW(CW)) u_ac (
        .i_clk, .i_en(en), .i_a($signed({1'b0, r_a5})), .i_b(r_c5), .o_p(p_ac)
    );

    // Coefficients wait alongside the discriminant products.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_dl[0]  <= r_a5;
            r_b_dl[0]  <= r_b5;
            r_cn_dl[0] <= r_c5[CW-1];
            for (int k = 1; k < 3; k++) begin
                r_a_dl[k]  <= r_a_dl[k-1];
                r_b_dl[k]  <= r_b_dl[k-1];
                r_cn_dl[k] <= r_cn_dl[k-1];
            end
        end
    end

    // Discriminant b^2 - 4ac.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a9    <= r_a_dl[2];
            r_b9    <= r_b_dl[2];
            r_cn9   <= r_cn_dl[2];
            r_disc9 <= p_bb - (DW'(p_ac) <<< 2);
        end
    end

    // Classification: zero direction, negative discriminant, tangent ray, sign of c.
    always_comb begin
        n_flags.miss    = (r_a9 == '0) || r_disc9[DW-1];
        n_flags.tangent = !r_disc9[DW-1] && (r_disc9[DW-2:2*FRAC_BITS] < i_disc_eps);
        n_flags.c_neg   = r_cn9;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a10     <= r_a9;
            r_b10     <= r_b9;
            r_disc10  <= r_disc9;
            r_flags10 <= n_flags;
        end
    end

    assign o_a     = r_a10;
    assign o_b     = r_b10;
    assign o_disc  = r_disc10;
    assign o_flags = r_flags10;

endmodule

`default_nettype wire

FILE: design/rsi_fifo.sv
// ----------------------------------------------------------------------------
// rsi_fifo
// Short queue that decouples the front from the back.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rsi_fifo #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = rsi_pkg::QUEUE_DEPTH
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire logic [DATA_W-1:0] i_data,
    output logic                   o_full,
    input  wire logic              i_pop,
    output logic [DATA_W-1:0]      o_data,
    output logic                   o_avail
);

    localparam int PW   = $clog2(DEPTH);
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [0:DEPTH-1];
    logic [PW-1:0]     r_wr, r_rd;
    logic [CNTW-1:0]   r_count;

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_full  = (r_count == CNTW'(DEPTH));
    assign o_avail = (r_count != '0);
    assign o_data  = r_mem[r_rd];

    `RSI_ASSERT_IMPL(a_fifo_bound, i_clk, i_rst_n, 1'b1, r_count <= CNTW'(DEPTH))
    `RSI_ASSERT_IMPL(a_fifo_pop_avail, i_clk, i_rst_n, i_pop, r_count != '0)
    `RSI_ASSERT_NEXT(a_fifo_fill, i_clk, i_rst_n, i_push && !i_pop, r_count == $past(r_count) + 1'b1)

endmodule

`default_nettype wire

FILE: design/rsi_back.sv
// ----------------------------------------------------------------------------
// rsi_back
// Takes classified items from the queue: square root of the discriminant,
// root selection, division by 2a with saturation, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rsi_back #(
    parameter int COORD_WIDTH = rsi_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = rsi_pkg::FRAC_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_avail,
    output logic                               o_pop,
    input  wire logic [2*COORD_WIDTH-1:0]      i_a,
    input  wire logic signed [2*COORD_WIDTH+3:0] i_b,
    input  wire logic signed [4*COORD_WIDTH+7:0] i_disc,
    input  wire rsi_pkg::t_flags               i_flags,
    input  wire logic [FRAC_BITS-1:0]          i_dist_eps,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic                               o_hit,
    output logic [COORD_WIDTH-2:0]             o_hit_distance
);

    localparam int W    = COORD_WIDTH;
    localparam int AW   = 2 * W;
    localparam int BW   = 2 * W + 4;
    localparam int DW   = 4 * W + 8;
    localparam int SW   = DW / 2;
    localparam int RW   = SW + 2;
    localparam int NW   = 2 * W + 6;
    localparam int NUMW = NW - 1 + FRAC_BITS;
    localparam int CMPW = ((NUMW > 3 * W) ? NUMW : 3 * W) + 1;
    localparam int DENW = AW + 1;
    localparam int QW   = W - 1;

    logic en;

    // Square root stages.
    logic [SW:0]          r_sq_v;
    logic [RW-1:0]        r_sq_rem  [0:SW];
    logic [SW-1:0]        r_sq_root [0:SW];
    logic [DW-1:0]        r_sq_dsh  [0:SW];
    logic [AW-1:0]        r_sq_a    [0:SW];
    logic signed [BW-1:0] r_sq_b    [0:SW];
    rsi_pkg::t_flags      r_sq_f    [0:SW];
    logic [RW-1:0]        n_sq_rem  [0:SW-1];
    logic [SW-1:0]        n_sq_root [0:SW-1];

    // Root selection stage.
    logic                 r_sel_v;
    logic signed [NW-1:0] r_sel_n;
    logic [AW-1:0]        r_sel_a;
    logic                 r_sel_miss;
    logic signed [NW-1:0] n_sel_n;

    // Division stages.
    logic [QW:0]          r_dv_v;
    logic [CMPW-1:0]      r_dv_rem  [0:QW];
    logic [DENW-1:0]      r_dv_den  [0:QW];
    logic [QW-1:0]        r_dv_q    [0:QW];
    logic                 r_dv_sat  [0:QW];
    logic                 r_dv_miss [0:QW];
    logic [CMPW-1:0]      n_dv_rem  [0:QW-1];
    logic [QW-1:0]        n_dv_q    [0:QW-1];
    logic [CMPW-1:0]      n_num;
    logic [CMPW-1:0]      n_lim;

    // Result register.
    logic                 r_o_valid;
    logic                 r_o_hit;
    logic [QW-1:0]        r_o_dist;
    logic [QW-1:0]        n_t;
    logic                 n_hit;

    // The whole back stalls only while a result waits on the consumer.
    assign en    = !r_o_valid || i_ready;
    assign o_pop = en && i_avail;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_v    <= '0;
            r_sel_v   <= 1'b0;
            r_dv_v    <= '0;
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_sq_v    <= {r_sq_v[SW-1:0], i_avail};
            r_sel_v   <= r_sq_v[SW];
            r_dv_v    <= {r_dv_v[QW-1:0], r_sel_v};
            r_o_valid <= r_dv_v[QW];
        end
    end

    // One root bit per stage, two discriminant bits shifted in each time.
    always_comb begin
        logic [RW-1:0] v_new;
        logic [RW-1:0] v_trial;
        for (int k = 0; k < SW; k++) begin
            v_new   = {r_sq_rem[k][RW-3:0], r_sq_dsh[k][DW-1 -: 2]};
            v_trial = {r_sq_root[k], 2'b01};
            if (v_new >= v_trial) begin
                n_sq_rem[k]  = v_new - v_trial;
                n_sq_root[k] = {r_sq_root[k][SW-2:0], 1'b1};
            end else begin
                n_sq_rem[k]  = v_new;
                n_sq_root[k] = {r_sq_root[k][SW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq_rem[0]  <= '0;
            r_sq_root[0] <= '0;
            r_sq_dsh[0]  <= i_disc;
            r_sq_a[0]    <= i_a;
            r_sq_b[0]    <= i_b;
            r_sq_f[0]    <= i_flags;
            for (int k = 0; k < SW; k++) begin
                r_sq_rem[k+1]  <= n_sq_rem[k];
                r_sq_root[k+1] <= n_sq_root[k];
                r_sq_dsh[k+1]  <= {r_sq_dsh[k][DW-3:0], 2'b00};
                r_sq_a[k+1]    <= r_sq_a[k];
                r_sq_b[k+1]    <= r_sq_b[k];
                r_sq_f[k+1]    <= r_sq_f[k];
            end
        end
    end

    // Numerator: -b for a tangent ray, the far root when c is negative,
    // the near root otherwise.
    always_comb begin
        logic signed [NW-1:0] v_nb;
        logic signed [NW-1:0] v_s;
        v_nb = -(NW'(r_sq_b[SW]));
        v_s  = NW'(r_sq_root[SW]);
        if (r_sq_f[SW].tangent) begin
            n_sel_n = v_nb;
        end else if (r_sq_f[SW].c_neg) begin
            n_sel_n = v_nb + v_s;
        end else begin
            n_sel_n = v_nb - v_s;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sel_n    <= n_sel_n;
            r_sel_a    <= r_sq_a[SW];
            r_sel_miss <= r_sq_f[SW].miss || n_sel_n[NW-1];
        end
    end

    // Saturation check: the quotient overflows when n*2^F >= 2a*2^(W-1).
    assign n_num = CMPW'(r_sel_n[NW-2:0]) << FRAC_BITS;
    assign n_lim = CMPW'(r_sel_a) << W;

    // Restoring division, one quotient bit per stage, most significant first.
    always_comb begin
        logic [CMPW-1:0] v_sh;
        for (int j = 0; j < QW; j++) begin
            v_sh = CMPW'(r_dv_den[j]) << (QW - 1 - j);
            if (r_dv_rem[j] >= v_sh) begin
                n_dv_rem[j] = r_dv_rem[j] - v_sh;
                n_dv_q[j]   = {r_dv_q[j][QW-2:0], 1'b1};
            end else begin
                n_dv_rem[j] = r_dv_rem[j];
                n_dv_q[j]   = {r_dv_q[j][QW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dv_rem[0]  <= n_num;
            r_dv_den[0]  <= {r_sel_a, 1'b0};
            r_dv_q[0]    <= '0;
            r_dv_sat[0]  <= (n_num >= n_lim);
            r_dv_miss[0] <= r_sel_miss;
            for (int j = 0; j < QW; j++) begin
                r_dv_rem[j+1]  <= n_dv_rem[j];
                r_dv_den[j+1]  <= r_dv_den[j];
                r_dv_q[j+1]    <= n_dv_q[j];
                r_dv_sat[j+1]  <= r_dv_sat[j];
                r_dv_miss[j+1] <= r_dv_miss[j];
            end
        end
    end

    // Distance threshold and result.
    assign n_t   = r_dv_sat[QW] ? '1 : r_dv_q[QW];
    assign n_hit = !r_dv_miss[QW] && (n_t >= i_dist_eps);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_hit  <= n_hit;
            r_o_dist <= n_hit ? n_t : '0;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_hit          = r_o_hit;
    assign o_hit_distance = r_o_dist;

    `RSI_ASSERT_IMPL(a_miss_zero, i_clk, i_rst_n, r_o_valid && !r_o_hit, r_o_dist == '0)
    `RSI_ASSERT_IMPL(a_hit_far_enough, i_clk, i_rst_n, r_o_valid && r_o_hit, r_o_dist >= i_dist_eps)

endmodule

`default_nettype wire

FILE: design/ray_sphere_intersection.sv
// Ray/sphere intersection. Each ray (origin and direction in object space,
// signed fixed point) is tested against the configured sphere; one result
// (hit flag and saturated hit distance) comes back per ray, in order. Rays
// enter one per clock while the output is being taken. On the way to a
// result each ray passes the coefficient front, the queue and the back
// (one stage per bit of the discriminant square root, one per quotient bit
// of the divider, plus an input register, select, overflow check and result
// register). Configuration registers are written through a plain
// write port and must only change while no ray is in flight.
// ----------------------------------------------------------------------------
// ray_sphere_intersection
// Top level: configuration registers, coefficient front, queue and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module ray_sphere_intersection #(
    parameter int COORD_WIDTH = rsi_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = rsi_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_valid,
    output logic                                       o_ready,
    input  wire logic signed [COORD_WIDTH-1:0]         i_origin_x,
    input  wire logic signed [COORD_WIDTH-1:0]         i_origin_y,
    input  wire logic signed [COORD_WIDTH-1:0]         i_origin_z,
    input  wire logic signed [COORD_WIDTH-1:0]         i_dir_x,
    input  wire logic signed [COORD_WIDTH-1:0]         i_dir_y,
    input  wire logic signed [COORD_WIDTH-1:0]         i_dir_z,
    output logic                                       o_valid,
    input  wire logic                                  i_ready,
    output logic                                       o_hit,
    output logic [COORD_WIDTH-2:0]                     o_hit_distance,
    input  wire logic                                  i_cfg_we,
    input  wire logic [rsi_pkg::CFG_INDEX_W-1:0]       i_cfg_index,
    input  wire logic [((COORD_WIDTH > 2*FRAC_BITS) ? COORD_WIDTH : 2*FRAC_BITS)-1:0]
                                                       i_cfg_data
);

    localparam int W  = COORD_WIDTH;
    localparam int AW = 2 * W;
    localparam int BW = 2 * W + 4;
    localparam int DW = 4 * W + 8;
    localparam int FW = $bits(rsi_pkg::t_flags);
    localparam int QD = FW + AW + BW + DW;

    logic signed [W-1:0]      r_center_x, r_center_y, r_center_z;
    logic [W-2:0]             r_radius;
    logic [2*FRAC_BITS-1:0]   r_disc_eps;
    logic [FRAC_BITS-1:0]     r_dist_eps;

    logic                     f_push, q_full, q_pop, q_avail;
    logic [AW-1:0]            f_a, q_a;
    logic signed [BW-1:0]     f_b, q_b;
    logic signed [DW-1:0]     f_disc, q_disc;
    rsi_pkg::t_flags          f_flags, q_flags;
    logic [QD-1:0]            q_out;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x <= '0;
            r_center_y <= '0;
            r_center_z <= '0;
            r_radius   <= (W-1)'(1) << FRAC_BITS;
            r_disc_eps <= (2*FRAC_BITS)'(rsi_pkg::DISC_EPS_RESET);
            r_dist_eps <= FRAC_BITS'(rsi_pkg::DIST_EPS_RESET);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                rsi_pkg::REG_CENTER_X: r_center_x <= i_cfg_data[W-1:0];
                rsi_pkg::REG_CENTER_Y: r_center_y <= i_cfg_data[W-1:0];
                rsi_pkg::REG_CENTER_Z: r_center_z <= i_cfg_data[W-1:0];
                rsi_pkg::REG_RADIUS:   r_radius   <= i_cfg_data[W-2:0];
                rsi_pkg::REG_DISC_EPS: r_disc_eps <= i_cfg_data[2*FRAC_BITS-1:0];
                rsi_pkg::REG_DIST_EPS: r_dist_eps <= i_cfg_data[FRAC_BITS-1:0];
                default: ;
            endcase
        end
    end

    rsi_front #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk, .i_rst_n,
        .i_valid, .o_ready,
        .i_origin_x, .i_origin_y, .i_origin_z,
        .i_dir_x, .i_dir_y, .i_dir_z,
        .i_center_x(r_center_x), .i_center_y(r_center_y), .i_center_z(r_center_z),
        .i_radius(r_radius), .i_disc_eps(r_disc_eps),
        .i_full(q_full), .o_push(f_push),
        .o_a(f_a), .o_b(f_b), .o_disc(f_disc), .o_flags(f_flags)
    );

    rsi_fifo #(.DATA_W(QD), .DEPTH(rsi_pkg::QUEUE_DEPTH)) u_queue (
        .i_clk, .i_rst_n,
        .i_push(f_push), .i_data({f_flags, f_a, f_b, f_disc}), .o_full(q_full),
        .i_pop(q_pop), .o_data(q_out), .o_avail(q_avail)
    );

    // Unpack the queue item.
    assign q_flags = q_out[QD-1 -: FW];
    assign q_a     = q_out[AW+BW+DW-1 -: AW];
    assign q_b     = q_out[BW+DW-1 -: BW];
    assign q_disc  = q_out[DW-1:0];

    rsi_back #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk, .i_rst_n,
        .i_avail(q_avail), .o_pop(q_pop),
        .i_a(q_a), .i_b(q_b), .i_disc(q_disc), .i_flags(q_flags),
        .i_dist_eps(r_dist_eps),
        .o_valid, .i_ready, .o_hit, .o_hit_distance
    );

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Ray/sphere intersection testbench
// Drives rays through the valid/ready input, takes results from the output
// channel and compares each one with a bit-exact model of the quadratic
// solver, across several sphere and threshold settings and random stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

    localparam int CW          = 32;
    localparam int FB          = 16;
    localparam int ONE         = 1 << FB;
    localparam int RAYS_PHASE  = 100;
    localparam int NUM_PHASES  = 7;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN       = 200;
    localparam int QUIET_LIMIT = 5000;
    localparam logic [rsi_pkg::CFG_INDEX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [rsi_pkg::CFG_INDEX_W-1:0] REG_SPARE_B = 3'd7;
    localparam logic [CW-2:0] DIST_MAX = '1;

    typedef logic signed [CW-1:0] coord_t;
    typedef logic signed [255:0]  wide_t;

    typedef struct packed {
        coord_t ox, oy, oz, dx, dy, dz;
    } ray_t;

    typedef struct packed {
        logic          hit;
        logic [CW-2:0] hit_dist;
    } hit_t;

    typedef struct packed {
        coord_t        cx, cy, cz;
        logic [CW-2:0] radius;
        logic [31:0]   disc_eps;
        logic [15:0]   dist_eps;
    } sphere_t;

    typedef struct packed {
        ray_t ray;
        logic known;
        hit_t res;
    } row_t;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_valid = 1'b0;
    logic          o_ready;
    coord_t        i_origin_x = '0, i_origin_y = '0, i_origin_z = '0;
    coord_t        i_dir_x = '0, i_dir_y = '0, i_dir_z = '0;
    logic          o_valid;
    logic          i_ready = 1'b0;
    logic          o_hit;
    logic [CW-2:0] o_hit_distance;
    logic          i_cfg_we = 1'b0;
    logic [rsi_pkg::CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [31:0]   i_cfg_data = '0;

    ray_sphere_intersection i_dut (
        .i_clk, .i_rst_n, .i_valid, .o_ready,
        .i_origin_x, .i_origin_y, .i_origin_z, .i_dir_x, .i_dir_y, .i_dir_z,
        .o_valid, .i_ready, .o_hit, .o_hit_distance,
        .i_cfg_we, .i_cfg_index, .i_cfg_data
    );

    sphere_t sphere;
    hit_t    pending_hits[$];
    int      mismatches = 0;
    bit      steady = 1'b0;
    bit      hold_req = 1'b0;
    row_t    rows[12];

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Integer square root, floor.
    function automatic logic [255:0] isqrt(input logic [255:0] v);
        logic [255:0] root, probe, trial;
        root  = '0;
        probe = 256'b1 << 254;
        while (probe > v) probe = probe >> 2;
        while (probe != 0) begin
            trial = root + probe;
            if (v >= trial) begin
                v    = v - trial;
                root = (root >> 1) + probe;
            end else begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return root;
    endfunction

    // Solves the ray/sphere quadratic exactly and picks the visible root.
    function automatic hit_t solve_hit(input ray_t r, input sphere_t k);
        wide_t mx, my, mz, dx, dy, dz, a, b, c, disc, n, s, q, rr;
        hit_t  res;
        res = '0;
        mx = wide_t'(r.ox) - wide_t'(k.cx);
        my = wide_t'(r.oy) - wide_t'(k.cy);
        mz = wide_t'(r.oz) - wide_t'(k.cz);
        dx = wide_t'(r.dx);
        dy = wide_t'(r.dy);
        dz = wide_t'(r.dz);
        a = dx * dx + dy * dy + dz * dz;
        if (a == 0) return res;
        b  = 2 * (dx * mx + dy * my + dz * mz);
        rr = wide_t'({1'b0, k.radius});
        c  = mx * mx + my * my + mz * mz - rr * rr;
        disc = b * b - 4 * a * c;
        if (disc < 0) return res;
        if (disc < (wide_t'({1'b0, k.disc_eps}) <<< (2 * FB))) begin
            n = -b;
        end else begin
            s = wide_t'(isqrt(disc));
            n = (c < 0) ? -b + s : -b - s;
        end
        if (n < 0) return res;
        q = (n <<< FB) / (a <<< 1);
        if (q < wide_t'({1'b0, k.dist_eps})) return res;
        if (q > wide_t'({1'b0, DIST_MAX})) q = wide_t'({1'b0, DIST_MAX});
        res.hit      = 1'b1;
        res.hit_dist = q[CW-2:0];
        return res;
    endfunction

    function automatic int rand_span(input int span);
        return int'($urandom_range(2 * span)) - span;
    endfunction

    // Mostly rays aimed near the sphere, plus raw noise, short random directions and zero directions.
    function automatic ray_t make_ray(input sphere_t k);
        ray_t r;
        int   pick, shift, tx, ty, tz, jit;
        pick = $urandom_range(99);
        if (pick < 15) begin
            r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        end else begin
            r.ox = k.cx + rand_span(1 << 20);
            r.oy = k.cy + rand_span(1 << 20);
            r.oz = k.cz + rand_span(1 << 20);
            if (pick < 20) begin
                r.dx = '0;
                r.dy = '0;
                r.dz = '0;
            end else if (pick < 35) begin
                r.dx = rand_span(1 << 17);
                r.dy = rand_span(1 << 17);
                r.dz = rand_span(1 << 17);
            end else begin
                jit   = int'(k.radius);
                tx    = k.cx + rand_span(jit);
                ty    = k.cy + rand_span(jit);
                tz    = k.cz + rand_span(jit);
                shift = $urandom_range(6);
                r.dx  = (tx - r.ox) >>> shift;
                r.dy  = (ty - r.oy) >>> shift;
                r.dz  = (tz - r.oz) >>> shift;
            end
        end
        return r;
    endfunction

    // Writes every register, plus the two unused indexes, and updates the copy.
    task automatic load_sphere(input sphere_t k);
        logic [rsi_pkg::CFG_INDEX_W-1:0] idx[8];
        logic [31:0]                     val[8];
        idx = '{rsi_pkg::REG_CENTER_X, rsi_pkg::REG_CENTER_Y, rsi_pkg::REG_CENTER_Z,
                rsi_pkg::REG_RADIUS, rsi_pkg::REG_DISC_EPS, rsi_pkg::REG_DIST_EPS,
                REG_SPARE_A, REG_SPARE_B};
        val = '{k.cx, k.cy, k.cz, {1'b0, k.radius}, k.disc_eps,
                {16'd0, k.dist_eps}, $urandom, $urandom};
        for (int i = 0; i < 8; i++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= idx[i];
            i_cfg_data  <= val[i];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        sphere = k;
    endtask

    // Offers one item and holds it until accepted, then files its result.
    task automatic send_ray(input ray_t r, input hit_t res);
        while (!steady && $urandom_range(99) < 17) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_origin_x <= r.ox;
        i_origin_y <= r.oy;
        i_origin_z <= r.oz;
        i_dir_x    <= r.dx;
        i_dir_y    <= r.dy;
        i_dir_z    <= r.dz;
        do @(posedge i_clk); while (!o_ready);
        pending_hits.push_back(res);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (pending_hits.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // Result side: check each item and draw the next ready.
    initial begin
        hit_t want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                if (pending_hits.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected item: hit %0d dist %0d", o_hit, o_hit_distance);
                end else begin
                    want = pending_hits.pop_front();
                    if (o_hit !== want.hit || o_hit_distance !== want.hit_dist) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected hit %0d dist %0d, got hit %0d dist %0d",
                                     want.hit, want.hit_dist, o_hit, o_hit_distance);
                    end
                end
            end
            if (hold_req) begin
                i_ready  <= 1'b0;
                hold_req = 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            i_ready <= steady || ($urandom_range(99) >= 17);
        end
    end

    // Watchdog: ends the run when nothing moves for too long.
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n)
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // Main sequence: reset, directed table, then corner and random phases.
    initial begin
        sphere_t k;
        row_t    row;
        hit_t    res;
        sphere = '{cx: '0, cy: '0, cz: '0, radius: 31'(ONE), disc_eps: 32'd1,
                   dist_eps: 16'd66};
        rows[0]  = '{'{0, 0, -5 * ONE, 0, 0, ONE}, 1'b1, '{1'b1, 31'(4 * ONE)}};
        rows[1]  = '{'{3 * ONE, -ONE, 7, 0, 0, 0}, 1'b1, '{1'b0, 31'd0}};
        rows[2]  = '{'{0, 0, 0, 0, 0, ONE}, 1'b1, '{1'b1, 31'(ONE)}};
        rows[3]  = '{'{0, 0, 5 * ONE, 0, 0, ONE}, 1'b1, '{1'b0, 31'd0}};
        rows[4]  = '{'{0, 2 * ONE, -5 * ONE, 0, 0, ONE}, 1'b1, '{1'b0, 31'd0}};
        rows[5]  = '{'{0, ONE, -5 * ONE, 0, 0, ONE}, 1'b1, '{1'b1, 31'(5 * ONE)}};
        rows[6]  = '{'{0, 0, -ONE, 0, 0, ONE}, 1'b1, '{1'b0, 31'd0}};
        rows[7]  = '{'{0, 0, -5 * ONE, 0, 0, 1}, 1'b1, '{1'b1, DIST_MAX}};
        rows[8]  = '{'{0, 0, -5 * ONE, 0, 0, -ONE}, 1'b1, '{1'b0, 31'd0}};
        rows[9]  = '{'{32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                       32'h80000000, 32'h80000000, 32'h80000000}, 1'b0, '0};
        rows[10] = '{'{32'h80000000, 32'h80000000, 32'h80000000,
                       32'h7fffffff, 32'h7fffffff, 32'h7fffffff}, 1'b0, '0};
        rows[11] = '{'{-3 * ONE, 0, 0, 32'h80000000, 0, 0}, 1'b0, '0};

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rays against the reset sphere.
        for (int i = 0; i < 12; i++) begin
            row = rows[i];
            res = row.known ? row.res : solve_hit(row.ray, sphere);
            send_ray(row.ray, res);
        end
        drain_results();

        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p == 0) begin
                k = '{cx: 32'h7fffffff, cy: 32'h7fffffff, cz: 32'h7fffffff,
                      radius: DIST_MAX, disc_eps: 32'hffffffff, dist_eps: 16'd0};
            end else if (p == 1) begin
                k = '{cx: 32'h80000000, cy: 32'h80000000, cz: 32'h80000000,
                      radius: '0, disc_eps: 32'd0, dist_eps: 16'hffff};
            end else begin
                k.cx       = rand_span(1 << 20);
                k.cy       = rand_span(1 << 20);
                k.cz       = rand_span(1 << 20);
                k.radius   = 31'($urandom_range(1 << 19, 1 << 14));
                k.disc_eps = $urandom_range(3);
                k.dist_eps = 16'($urandom_range(200));
            end
            load_sphere(k);
            steady = (p == 2);
            if (p == 3) hold_req = 1'b1;
            for (int i = 0; i < RAYS_PHASE; i++) begin
                row.ray = make_ray(sphere);
                send_ray(row.ray, solve_hit(row.ray, sphere));
            end
            // Pause offering until the block has returned everything.
            drain_results();
        end

        repeat (DRAIN) @(posedge i_clk);
        if (mismatches == 0 && pending_hits.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire
